### sv/s64dc_pkg.sv
// Shared types, constants and the BCD adjust-and-shift step for the
// signed 64-bit to decimal text converter. No dependencies.
`timescale 1ns / 1ps

package s64dc_pkg;

  localparam int MAG_W       = 64;
  localparam int DIGIT_COUNT = 20;
  localparam int BCD_W       = 4 * DIGIT_COUNT;
  localparam int STEP_BITS   = 4;
  localparam int CONV_STEPS  = MAG_W / STEP_BITS;
  localparam int CNT_W       = $clog2(CONV_STEPS);
  localparam int IDX_W       = $clog2(DIGIT_COUNT);

  localparam logic [CNT_W-1:0] LAST_STEP  = CNT_W'(CONV_STEPS - 1);
  localparam logic [IDX_W-1:0] LAST_DIGIT = IDX_W'(DIGIT_COUNT - 1);

  localparam logic [5:0] CHAR_MINUS    = 6'd45;
  localparam logic [1:0] CHAR_DIGIT_HI = 2'b11;  // '0' is 6'b110000

  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
  } item_t;

  typedef struct packed {
    logic             neg;
    logic [BCD_W-1:0] bcd;
  } digits_t;

  // One double-dabble step: add 3 to every digit of 5 or more, then shift in a bit.
  function automatic logic [BCD_W-1:0] dabble_step(input logic [BCD_W-1:0] bcd,
                                                   input logic in_bit);
    logic [BCD_W-1:0] adj;
    adj = bcd;
    for (int d = 0; d < DIGIT_COUNT; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end
    end
    return {adj[BCD_W-2:0], in_bit};
  endfunction

endpackage

### sv/s64dc_front.sv
// Front stage: takes a signed value, splits it into sign and magnitude.
// Depends on s64dc_pkg.
`timescale 1ns / 1ps

module s64dc_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  logic signed [63:0]  value,
  output logic                out_vld,
  input  logic                out_rdy,
  output s64dc_pkg::item_t    out_item
);
  import s64dc_pkg::*;

  logic  vld;
  item_t item;
  logic  in_rdy;

  assign in_rdy   = !vld || out_rdy;
  assign full     = !in_rdy;
  assign out_vld  = vld;
  assign out_item = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (in_rdy) begin
      vld <= push;
    end
  end

  // Unsigned negation also covers the most negative value (magnitude 2^63).
  always_ff @(posedge clk) begin
    if (push && in_rdy) begin
      item.neg <= value[63];
      item.mag <= value[63] ? (MAG_W'(0) - MAG_W'(value)) : MAG_W'(value);
    end
  end

endmodule

### sv/s64dc_queue.sv
// Two-entry queue between the front stage and the converter.
// Depends on s64dc_pkg.
`timescale 1ns / 1ps

module s64dc_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  output logic             in_rdy,
  input  s64dc_pkg::item_t in_item,
  output logic             out_vld,
  input  logic             out_rdy,
  output s64dc_pkg::item_t out_item
);
  import s64dc_pkg::*;

  item_t      mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  logic       rd_en;

  assign in_rdy   = (count != 2'd2);
  assign out_vld  = (count != 2'd0);
  assign out_item = mem[rd_ptr];
  assign wr_en    = in_vld && in_rdy;
  assign rd_en    = out_vld && out_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= !wr_ptr;
      if (rd_en) rd_ptr <= !rd_ptr;
      case ({wr_en, rd_en})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= in_item;
    end
  end

endmodule

### sv/s64dc_conv.sv
// Binary to BCD converter: four double-dabble steps per cycle while busy, until all 64
// bits are in; it loads a new value only when idle and its result taken. Depends on s64dc_pkg.
`timescale 1ns / 1ps

module s64dc_conv (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  output logic               in_rdy,
  input  s64dc_pkg::item_t   in_item,
  output logic               out_vld,
  input  logic               out_rdy,
  output s64dc_pkg::digits_t out_digits
);
  import s64dc_pkg::*;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [MAG_W-1:0] sh;
  logic [BCD_W-1:0] bcd;
  logic             neg;
  logic [BCD_W-1:0] bcd_next;
  logic             load;

  assign in_rdy     = !busy && (!done || out_rdy);
  assign load       = in_vld && in_rdy;
  assign out_vld    = done;
  assign out_digits = '{neg: neg, bcd: bcd};

  always_comb begin
    bcd_next = bcd;
    for (int s = 0; s < STEP_BITS; s++) begin
      bcd_next = dabble_step(bcd_next, sh[MAG_W-1-s]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + CNT_W'(1);
      if (cnt == LAST_STEP) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else if (done && out_rdy) begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      sh  <= in_item.mag;
      neg <= in_item.neg;
      bcd <= '0;
    end else if (busy) begin
      sh  <= {sh[MAG_W-STEP_BITS-1:0], STEP_BITS'(0)};
      bcd <= bcd_next;
    end
  end

endmodule

### sv/s64dc_emit.sv
// Character emitter: optional minus sign, then twenty ASCII digits, one beat a cycle
// while pop is high. Depends on s64dc_pkg.
`timescale 1ns / 1ps

module s64dc_emit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  output logic               in_rdy,
  input  s64dc_pkg::digits_t in_digits,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         character,
  output logic               is_last
);
  import s64dc_pkg::*;

  logic             vld;
  logic             sign_pend;
  logic [IDX_W-1:0] idx;
  logic [BCD_W-1:0] digits;
  logic             take;
  logic             load;

  assign empty     = !vld;
  assign is_last   = !sign_pend && (idx == LAST_DIGIT);
  assign character = sign_pend ? CHAR_MINUS : {CHAR_DIGIT_HI, digits[BCD_W-1 -: 4]};
  assign take      = vld && pop;
  assign in_rdy    = !vld || (take && is_last);
  assign load      = in_vld && in_rdy;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= 1'b0;
      sign_pend <= 1'b0;
      idx       <= '0;
    end else if (load) begin
      vld       <= 1'b1;
      sign_pend <= in_digits.neg;
      idx       <= '0;
    end else if (take) begin
      if (sign_pend) begin
        sign_pend <= 1'b0;
      end else if (is_last) begin
        vld <= 1'b0;
      end else begin
        idx <= idx + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      digits <= in_digits.bcd;
    end else if (take && !sign_pend) begin
      digits <= {digits[BCD_W-5:0], 4'd0};
    end
  end

endmodule

### sv/signed64_to_decimal_chars.sv
// Signed 64-bit value to decimal ASCII text. Each value pushed comes out as a
// run of beats: a minus sign if the value is negative, then exactly twenty
// digits, most significant first, leading zeros kept; is_last marks the final
// digit. A value takes twenty beats of the result port (non-negative) or
// twenty-one (negative) at one beat per cycle while pop is high, and that port
// sets the sustained rate. The binary to BCD conversion overlaps the output of
// the previous value; a two-entry queue and the front register absorb stalls.
// Top level; depends on s64dc_pkg, s64dc_front, s64dc_queue, s64dc_conv, s64dc_emit.
`timescale 1ns / 1ps

module signed64_to_decimal_chars (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  output logic               full,
  input  logic signed [63:0] value,
  output logic               empty,
  input  logic               pop,
  output logic [5:0]         character,
  output logic               is_last
);
  import s64dc_pkg::*;

  logic    f_vld;
  logic    f_rdy;
  item_t   f_item;
  logic    q_vld;
  logic    q_rdy;
  item_t   q_item;
  logic    c_vld;
  logic    c_rdy;
  digits_t c_digits;

  s64dc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .value    (value),
    .out_vld  (f_vld),
    .out_rdy  (f_rdy),
    .out_item (f_item)
  );

  s64dc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (f_vld),
    .in_rdy   (f_rdy),
    .in_item  (f_item),
    .out_vld  (q_vld),
    .out_rdy  (q_rdy),
    .out_item (q_item)
  );

  s64dc_conv u_conv (
    .clk        (clk),
    .rst        (rst),
    .in_vld     (q_vld),
    .in_rdy     (q_rdy),
    .in_item    (q_item),
    .out_vld    (c_vld),
    .out_rdy    (c_rdy),
    .out_digits (c_digits)
  );

  s64dc_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_vld    (c_vld),
    .in_rdy    (c_rdy),
    .in_digits (c_digits),
    .empty     (empty),
    .pop       (pop),
    .character (character),
    .is_last   (is_last)
  );

endmodule
